>>> rtl/xpm_image_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef XPM_IMAGE_DECODER_MACROS_SVH
`define XPM_IMAGE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XID_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/xid_pkg.sv
package xid_pkg;

    // Default limits of the decoder.
    localparam int MAX_COLOURS_DEF    = 1024;
    localparam int MAX_DIMENSION_DEF  = 2048;
    localparam int MAX_NAME_CHARS_DEF = 4;
    localparam int PALETTE_LIMIT_DEF  = 256;

    // Saturation points of the header values and the line byte counter.
    localparam logic [15:0] HDR_SAT   = 16'hFFFF;
    localparam logic [13:0] COUNT_MAX = 14'h3FFF;

    // Depth of the command queue between the parser and the table unit.
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes.
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_EOL  = 2'd1,
        OP_EOF  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    // Result kinds.
    localparam logic [2:0] K_COLOUR = 3'd0;
    localparam logic [2:0] K_TABLE  = 3'd1;
    localparam logic [2:0] K_PIXEL  = 3'd2;
    localparam logic [2:0] K_IMAGE  = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_SHORT   = 3'd0;
    localparam logic [2:0] ERR_PARSE   = 3'd1;
    localparam logic [2:0] ERR_SPEC    = 3'd2;
    localparam logic [2:0] ERR_ROW_LEN = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] text_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  colour_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        direct_mode;
        logic [10:0] column;
        logic [10:0] row_number;
        logic [2:0]  error_code;
        logic [10:0] colours_defined;
        logic        last_of_run;
    } t_out_word;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COLOURS,
        PH_ROWS,
        PH_STOP
    } t_phase;

    // Commands handed from the parser to the table unit.
    typedef enum logic [2:0] {
        CMD_FAIL,
        CMD_TABLE,
        CMD_COLOUR,
        CMD_LOOKUP,
        CMD_ROW_END
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [31:0] name;
        logic [23:0] rgb;
        logic [10:0] x;
        logic [10:0] row;
        logic [2:0]  code;
        logic        store;
        logic        finish;
        logic        hzero;
        logic        len_ok;
        logic        last_row;
    } t_cmd;

    // Queue handshake between the two halves.
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Table unit sequencer.
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_COMPARE,
        B_EMIT
    } t_back_state;

    // Fixed text between a colour name and its hex digits.
    function automatic logic [7:0] mark_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = 8'h20;
            2'd1:    c = 8'h63;
            2'd2:    c = 8'h20;
            default: c = 8'h23;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/xpm_image_decoder.sv
// XPM text decoder.
// Input channel: i_valid/o_stall carry one word per line byte, end of line or
// end of input. Output channel: o_valid/i_stall carry one result word each;
// last_of_run marks the final result caused by an input word.
// A parser accepts a word whenever its two-entry command queue
// has room, so header and colour text streams at one word per cycle.
// With the table unit free, a colour, table, image or error result passes the
// command queue and the table unit's idle and emit states before it shows on
// o_valid; further results of the same word follow one per cycle while i_stall
// is low. The table unit searches newest entry first, each entry inspected in a
// read state and then a compare state; it takes no new command until a pixel is
// found and emitted or the name is found unknown. That search sets the pixel rate.
// A held o_valid keeps its word until i_stall drops; meanwhile the queue
// fills and o_stall then holds the sender off.
// Synchronous reset returns to the header phase with an empty table.
// After image complete or any error, further input words are taken and ignored.
`include "xpm_image_decoder_macros.svh"

module xpm_image_decoder #(
    parameter int MAX_COLOURS    = xid_pkg::MAX_COLOURS_DEF,
    parameter int MAX_DIMENSION  = xid_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_NAME_CHARS = xid_pkg::MAX_NAME_CHARS_DEF,
    parameter int PALETTE_LIMIT  = xid_pkg::PALETTE_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  xid_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output xid_pkg::t_out_word o_data
);

    xid_pkg::t_cmd    push_cmd, pop_cmd;
    xid_pkg::t_q_ctrl q_ctrl;
    xid_pkg::t_q_stat q_stat;
    logic             err_taken;
    logic             img_taken;

    // Front: parse and classify.
    xid_front #(
        .MAX_COLOURS    (MAX_COLOURS),
        .MAX_DIMENSION  (MAX_DIMENSION),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (q_ctrl.push),
        .o_cmd   (push_cmd),
        .i_qstat (q_stat)
    );

    // Command queue between the two halves.
    xid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_cmd   (push_cmd),
        .o_cmd   (pop_cmd),
        .o_stat  (q_stat)
    );

    // Back: colour table, lookup and result output.
    xid_back #(
        .MAX_COLOURS   (MAX_COLOURS),
        .PALETTE_LIMIT (PALETTE_LIMIT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_qstat (q_stat),
        .o_pop   (q_ctrl.pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Final result words as they are taken.
    assign err_taken = o_valid && !i_stall && (o_data.kind == xid_pkg::K_ERROR);
    assign img_taken = o_valid && !i_stall && (o_data.kind == xid_pkg::K_IMAGE);

    // The parser never pushes into a full queue.
    `XID_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, q_ctrl.push, !q_stat.full, "push while full")

    // The table unit never pops an empty queue.
    `XID_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, q_ctrl.pop, !q_stat.empty, "pop while empty")

    // Nothing follows an error once it is taken.
    `XID_ASSERT_NEXT(a_err_last, i_clk, i_rst_n, err_taken, !o_valid, "result after error")

    // Nothing follows image complete once it is taken.
    `XID_ASSERT_NEXT(a_img_last, i_clk, i_rst_n, img_taken, !o_valid, "result after image")

endmodule

>>> rtl/xid_front.sv
module xid_front #(
    parameter int MAX_COLOURS    = xid_pkg::MAX_COLOURS_DEF,
    parameter int MAX_DIMENSION  = xid_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_NAME_CHARS = xid_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  xid_pkg::t_in_word i_data,
    output logic             o_push,
    output xid_pkg::t_cmd    o_cmd,
    input  xid_pkg::t_q_stat i_qstat
);

    xid_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_hv [4];
    logic [15:0] n_hv [4];
    logic [2:0]  r_fpos, n_fpos;
    logic        r_innum, n_innum;
    logic [13:0] r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [23:0] r_hex, n_hex;
    logic        r_ok, n_ok;
    logic [15:0] r_seen, n_seen;
    logic [11:0] r_row, n_row;
    logic [1:0]  r_npos, n_npos;
    logic [11:0] r_x, n_x;

    logic        accept;
    logic [7:0]  b;
    logic [3:0]  dig;
    logic [19:0] prod;
    logic [2:0]  len;
    logic [14:0] p15;
    logic [14:0] len15;
    logic [15:0] wl;
    logic [15:0] seen_n;
    logic [3:0]  hexv;
    logic        hexok;
    logic [2:0]  fpos_e;
    logic [31:0] row_name;
    logic        spec_bad;

    // Value of an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else begin
            v = 5'd0;
        end
        return v;
    endfunction

    function automatic logic [1:0] fpos_idx();
        return r_fpos[1:0];
    endfunction

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign b       = i_data.text_byte;
    assign dig     = 4'(b - 8'h30);
    assign len     = r_hv[3][2:0];
    assign p15     = {1'b0, r_cnt};
    assign len15   = 15'(len);
    assign {hexok, hexv} = hex_digit(b);
    assign seen_n  = r_seen + 16'd1;
    assign fpos_e  = (r_innum && r_fpos < 3'd4) ? r_fpos + 3'd1 : r_fpos;
    assign row_name = (r_npos == 2'd0) ? {24'd0, b} : {r_shift[23:0], b};

    // Row length in bytes: width times name length, name length being 1 to 4.
    always_comb begin
        case (len)
            3'd1:    wl = r_hv[0];
            3'd2:    wl = {r_hv[0][14:0], 1'b0};
            3'd3:    wl = {r_hv[0][14:0], 1'b0} + r_hv[0];
            default: wl = {r_hv[0][13:0], 2'b00};
        endcase
    end

    // Header value times ten plus the new digit.
    assign prod = {1'b0, r_hv[fpos_idx()], 3'b000} + {3'b000, r_hv[fpos_idx()], 1'b0}
                + {16'd0, dig};

    assign spec_bad = ({16'd0, r_hv[0]} > 32'(MAX_DIMENSION))
                   || ({16'd0, r_hv[1]} > 32'(MAX_DIMENSION))
                   || ({16'd0, r_hv[2]} > 32'(MAX_COLOURS))
                   || (r_hv[3] == 16'd0)
                   || ({16'd0, r_hv[3]} > 32'(MAX_NAME_CHARS));

    // Parser: classifies each word and turns it into at most one command.
    always_comb begin
        n_phase = r_phase;
        n_hv    = r_hv;
        n_fpos  = r_fpos;
        n_innum = r_innum;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_hex   = r_hex;
        n_ok    = r_ok;
        n_seen  = r_seen;
        n_row   = r_row;
        n_npos  = r_npos;
        n_x     = r_x;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.row = r_row[10:0];
        if (accept && r_phase != xid_pkg::PH_STOP) begin
            unique case (xid_pkg::t_opcode'(i_data.opcode))
                xid_pkg::OP_EOF: begin
                    o_push     = 1'b1;
                    o_cmd.op   = xid_pkg::CMD_FAIL;
                    o_cmd.code = xid_pkg::ERR_SHORT;
                    o_cmd.row  = 11'd0;
                    n_phase    = xid_pkg::PH_STOP;
                end
                xid_pkg::OP_BYTE: begin
                    if (r_cnt != xid_pkg::COUNT_MAX) begin
                        n_cnt = r_cnt + 14'd1;
                    end
                    case (r_phase)
                        xid_pkg::PH_HEADER: begin
                            if (r_fpos < 3'd4 && r_ok) begin
                                if (b >= 8'h30 && b <= 8'h39) begin
                                    if (r_innum) begin
                                        if (r_hv[fpos_idx()] == 16'd0) begin
                                            n_ok = 1'b0;
                                        end else if (prod > {4'd0, xid_pkg::HDR_SAT}) begin
                                            n_hv[fpos_idx()] = xid_pkg::HDR_SAT;
                                        end else begin
                                            n_hv[fpos_idx()] = prod[15:0];
                                        end
                                    end else begin
                                        n_innum          = 1'b1;
                                        n_hv[fpos_idx()] = {12'd0, dig};
                                    end
                                end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
                                    if (r_innum) begin
                                        n_innum = 1'b0;
                                        n_fpos  = r_fpos + 3'd1;
                                    end
                                end else begin
                                    n_ok = 1'b0;
                                end
                            end
                        end
                        xid_pkg::PH_COLOURS: begin
                            if (p15 < len15) begin
                                n_shift = {r_shift[23:0], b};
                            end else if (p15 < len15 + 15'd4) begin
                                if (b != xid_pkg::mark_char(2'(p15 - len15))) begin
                                    n_ok = 1'b0;
                                end
                            end else if (p15 < len15 + 15'd10) begin
                                if (!hexok) begin
                                    n_ok = 1'b0;
                                end else begin
                                    n_hex = {r_hex[19:0], hexv};
                                end
                            end
                        end
                        default: begin
                            // Pixel row: collect one name, then hand it for lookup.
                            n_shift = row_name;
                            if (r_npos == 2'(len - 3'd1)) begin
                                n_npos = 2'd0;
                                if ({4'd0, r_x} < r_hv[0]) begin
                                    o_push     = 1'b1;
                                    o_cmd.op   = xid_pkg::CMD_LOOKUP;
                                    o_cmd.name = row_name;
                                    o_cmd.x    = r_x[10:0];
                                end
                                if (r_x != 12'hFFF) begin
                                    n_x = r_x + 12'd1;
                                end
                            end else begin
                                n_npos = r_npos + 2'd1;
                            end
                        end
                    endcase
                end
                xid_pkg::OP_EOL: begin
                    case (r_phase)
                        xid_pkg::PH_HEADER: begin
                            n_fpos = fpos_e;
                            if (!r_ok || fpos_e < 3'd4) begin
                                o_push     = 1'b1;
                                o_cmd.op   = xid_pkg::CMD_FAIL;
                                o_cmd.code = xid_pkg::ERR_PARSE;
                                o_cmd.row  = 11'd0;
                                n_phase    = xid_pkg::PH_STOP;
                            end else if (spec_bad) begin
                                o_push     = 1'b1;
                                o_cmd.op   = xid_pkg::CMD_FAIL;
                                o_cmd.code = xid_pkg::ERR_SPEC;
                                o_cmd.row  = 11'd0;
                                n_phase    = xid_pkg::PH_STOP;
                            end else if (r_hv[2] == 16'd0) begin
                                o_push      = 1'b1;
                                o_cmd.op    = xid_pkg::CMD_TABLE;
                                o_cmd.hzero = (r_hv[1] == 16'd0);
                                n_row       = 12'd0;
                                n_phase     = (r_hv[1] == 16'd0) ? xid_pkg::PH_STOP
                                                                 : xid_pkg::PH_ROWS;
                            end else begin
                                n_phase = xid_pkg::PH_COLOURS;
                            end
                        end
                        xid_pkg::PH_COLOURS: begin
                            o_push       = 1'b1;
                            o_cmd.op     = xid_pkg::CMD_COLOUR;
                            o_cmd.name   = r_shift;
                            o_cmd.rgb    = r_hex;
                            o_cmd.store  = r_ok && (p15 >= len15 + 15'd10);
                            o_cmd.finish = (seen_n >= r_hv[2]);
                            o_cmd.hzero  = (r_hv[1] == 16'd0);
                            n_seen       = seen_n;
                            if (seen_n >= r_hv[2]) begin
                                n_row   = 12'd0;
                                n_phase = (r_hv[1] == 16'd0) ? xid_pkg::PH_STOP
                                                             : xid_pkg::PH_ROWS;
                            end
                        end
                        default: begin
                            o_push         = 1'b1;
                            o_cmd.op       = xid_pkg::CMD_ROW_END;
                            o_cmd.len_ok   = ({2'd0, r_cnt} == wl);
                            o_cmd.last_row = ({4'd0, r_row} + 16'd1 >= r_hv[1]);
                            if ({2'd0, r_cnt} != wl) begin
                                n_phase = xid_pkg::PH_STOP;
                            end else begin
                                n_row = r_row + 12'd1;
                                if ({4'd0, r_row} + 16'd1 >= r_hv[1]) begin
                                    n_phase = xid_pkg::PH_STOP;
                                end
                            end
                        end
                    endcase
                    // Every line mark starts a fresh line.
                    n_cnt   = 14'd0;
                    n_shift = 32'd0;
                    n_hex   = 24'd0;
                    n_ok    = 1'b1;
                    n_innum = 1'b0;
                    n_npos  = 2'd0;
                    n_x     = 12'd0;
                end
                xid_pkg::OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xid_pkg::PH_HEADER;
            r_hv    <= '{default: 16'd0};
            r_fpos  <= 3'd0;
            r_innum <= 1'b0;
            r_cnt   <= 14'd0;
            r_shift <= 32'd0;
            r_hex   <= 24'd0;
            r_ok    <= 1'b1;
            r_seen  <= 16'd0;
            r_row   <= 12'd0;
            r_npos  <= 2'd0;
            r_x     <= 12'd0;
        end else begin
            r_phase <= n_phase;
            r_hv    <= n_hv;
            r_fpos  <= n_fpos;
            r_innum <= n_innum;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_hex   <= n_hex;
            r_ok    <= n_ok;
            r_seen  <= n_seen;
            r_row   <= n_row;
            r_npos  <= n_npos;
            r_x     <= n_x;
        end
    end

endmodule

>>> rtl/xid_queue.sv
module xid_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xid_pkg::t_q_ctrl i_ctrl,
    input  xid_pkg::t_cmd    i_cmd,
    output xid_pkg::t_cmd    o_cmd,
    output xid_pkg::t_q_stat o_stat
);

    localparam int QAW = (xid_pkg::QUEUE_DEPTH > 1) ? $clog2(xid_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(xid_pkg::QUEUE_DEPTH + 1);

    xid_pkg::t_cmd r_slot [xid_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_fill;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_fill == QCW'(xid_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_cmd        = r_slot[r_rp];
    assign do_push      = i_ctrl.push && !o_stat.full;
    assign do_pop       = i_ctrl.pop && !o_stat.empty;

    // Pointer wrap for the command slots.
    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == QAW'(xid_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wp <= bump(r_wp);
            end
            if (do_pop) begin
                r_rp <= bump(r_rp);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> rtl/xid_back.sv
module xid_back #(
    parameter int MAX_COLOURS   = xid_pkg::MAX_COLOURS_DEF,
    parameter int PALETTE_LIMIT = xid_pkg::PALETTE_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xid_pkg::t_cmd     i_cmd,
    input  xid_pkg::t_q_stat  i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output xid_pkg::t_out_word o_data
);

    localparam int AW = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;
    localparam int CW = $clog2(MAX_COLOURS + 1);

    xid_pkg::t_back_state r_state, n_state;
    xid_pkg::t_cmd        r_cmd, n_cmd;
    xid_pkg::t_out_word   r_prim, n_prim;
    xid_pkg::t_out_word   r_out, n_out;
    xid_pkg::t_out_word   emit_word;
    logic [CW-1:0] r_count, n_count;
    logic          r_unknown, n_unknown;
    logic [10:0]   r_ucol, n_ucol;
    logic          r_stopped, n_stopped;
    logic [2:0]    r_mask, n_mask, emit_mask;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_ov, n_ov;
    logic [55:0]   r_rdata;
    logic [55:0]   r_table [MAX_COLOURS];
    logic          we;
    logic          direct;
    logic          room;
    logic          can_load;

    assign direct   = (int'(r_count) > PALETTE_LIMIT);
    assign room     = (int'(r_count) < MAX_COLOURS);
    assign can_load = !r_ov || !i_stall;
    assign o_valid  = r_ov;
    assign o_data   = r_out;

    // Next word to emit: the primary result, then table complete, then image complete.
    always_comb begin
        emit_word = '0;
        emit_mask = r_mask;
        if (r_mask[0]) begin
            emit_word    = r_prim;
            emit_mask[0] = 1'b0;
        end else if (r_mask[1]) begin
            emit_word.kind            = xid_pkg::K_TABLE;
            emit_word.direct_mode     = direct;
            emit_word.colours_defined = 11'(r_count);
            emit_mask[1]              = 1'b0;
        end else begin
            emit_word.kind        = xid_pkg::K_IMAGE;
            emit_word.direct_mode = direct;
            emit_mask[2]          = 1'b0;
        end
        emit_word.last_of_run = (emit_mask == 3'b000);
    end

    // Sequencer: takes commands, searches the table and emits results.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_prim    = r_prim;
        n_count   = r_count;
        n_unknown = r_unknown;
        n_ucol    = r_ucol;
        n_stopped = r_stopped;
        n_mask    = r_mask;
        n_idx     = r_idx;
        n_ov      = r_ov && i_stall;
        n_out     = r_out;
        o_pop     = 1'b0;
        we        = 1'b0;
        unique case (r_state)
            xid_pkg::B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_prim = '0;
                    n_mask = 3'b000;
                    if (!r_stopped) begin
                        case (i_cmd.op)
                            xid_pkg::CMD_FAIL: begin
                                n_prim.kind       = xid_pkg::K_ERROR;
                                n_prim.error_code = i_cmd.code;
                                n_prim.column     = i_cmd.x;
                                n_prim.row_number = i_cmd.row;
                                n_mask            = 3'b001;
                                n_stopped         = 1'b1;
                            end
                            xid_pkg::CMD_TABLE: begin
                                n_mask    = {i_cmd.hzero, 2'b10};
                                n_stopped = i_cmd.hzero;
                            end
                            xid_pkg::CMD_COLOUR: begin
                                if (i_cmd.store && room) begin
                                    we                  = 1'b1;
                                    n_prim.kind         = xid_pkg::K_COLOUR;
                                    n_prim.colour_index = 10'(r_count);
                                    n_prim.red          = i_cmd.rgb[23:16];
                                    n_prim.green        = i_cmd.rgb[15:8];
                                    n_prim.blue         = i_cmd.rgb[7:0];
                                    n_count             = r_count + 1'b1;
                                end
                                n_mask = {i_cmd.finish && i_cmd.hzero, i_cmd.finish,
                                          i_cmd.store && room};
                                n_stopped = i_cmd.finish && i_cmd.hzero;
                            end
                            xid_pkg::CMD_LOOKUP: begin
                                if (!r_unknown) begin
                                    if (r_count == '0) begin
                                        n_unknown = 1'b1;
                                        n_ucol    = i_cmd.x;
                                    end else begin
                                        n_idx   = AW'(r_count - 1'b1);
                                        n_state = xid_pkg::B_READ;
                                    end
                                end
                            end
                            xid_pkg::CMD_ROW_END: begin
                                n_unknown = 1'b0;
                                if (!i_cmd.len_ok) begin
                                    n_prim.kind       = xid_pkg::K_ERROR;
                                    n_prim.error_code = xid_pkg::ERR_ROW_LEN;
                                    n_prim.row_number = i_cmd.row;
                                    n_mask            = 3'b001;
                                    n_stopped         = 1'b1;
                                end else if (r_unknown) begin
                                    n_prim.kind       = xid_pkg::K_ERROR;
                                    n_prim.error_code = xid_pkg::ERR_UNKNOWN;
                                    n_prim.column     = r_ucol;
                                    n_prim.row_number = i_cmd.row;
                                    n_mask            = 3'b001;
                                    n_stopped         = 1'b1;
                                end else if (i_cmd.last_row) begin
                                    n_mask    = 3'b100;
                                    n_stopped = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (n_mask != 3'b000) begin
                            n_state = xid_pkg::B_EMIT;
                        end
                    end
                end
            end
            xid_pkg::B_READ: begin
                n_state = xid_pkg::B_COMPARE;
            end
            xid_pkg::B_COMPARE: begin
                // Newest entry first, so a repeated name resolves to its last definition.
                if (r_rdata[55:24] == r_cmd.name) begin
                    n_prim              = '0;
                    n_prim.kind         = xid_pkg::K_PIXEL;
                    n_prim.colour_index = 10'(r_idx);
                    n_prim.red          = r_rdata[23:16];
                    n_prim.green        = r_rdata[15:8];
                    n_prim.blue         = r_rdata[7:0];
                    n_prim.direct_mode  = direct;
                    n_prim.column       = r_cmd.x;
                    n_prim.row_number   = r_cmd.row;
                    n_mask              = 3'b001;
                    n_state             = xid_pkg::B_EMIT;
                end else if (r_idx == '0) begin
                    n_unknown = 1'b1;
                    n_ucol    = r_cmd.x;
                    n_state   = xid_pkg::B_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = xid_pkg::B_READ;
                end
            end
            xid_pkg::B_EMIT: begin
                if (can_load) begin
                    n_ov   = 1'b1;
                    n_out  = emit_word;
                    n_mask = emit_mask;
                    if (emit_mask == 3'b000) begin
                        n_state = xid_pkg::B_IDLE;
                    end
                end
            end
            default: begin
                n_state = xid_pkg::B_IDLE;
            end
        endcase
    end

    // Colour table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_table[r_count[AW-1:0]] <= {i_cmd.name, i_cmd.rgb};
        end
        r_rdata <= r_table[r_idx];
    end

    // Sequencer and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= xid_pkg::B_IDLE;
            r_count   <= '0;
            r_unknown <= 1'b0;
            r_ucol    <= 11'd0;
            r_stopped <= 1'b0;
            r_mask    <= 3'b000;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_unknown <= n_unknown;
            r_ucol    <= n_ucol;
            r_stopped <= n_stopped;
            r_mask    <= n_mask;
            r_ov      <= n_ov;
        end
        r_cmd  <= n_cmd;
        r_prim <= n_prim;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

endmodule
